/* hdl/id_table_insert_search_sort_defines.svh */
// Assertion macros for the ID table block.
// Used by the top level; needs clk and rst_n in scope at the point of use.
`ifndef ID_TABLE_INSERT_SEARCH_SORT_DEFINES_SVH
`define ID_TABLE_INSERT_SEARCH_SORT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define IDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define IDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/idtbl_pkg.sv */
// Shared types and codes for the ID table block.
// No dependencies; imported by idtbl_store and id_table_insert_search_sort.
package idtbl_pkg;

  typedef logic signed [31:0] id_t;

  // Operation codes carried in the kind field
  localparam logic [2:0] KIND_INSERT  = 3'd0;
  localparam logic [2:0] KIND_DELETE  = 3'd1;
  localparam logic [2:0] KIND_UPDATE  = 3'd2;
  localparam logic [2:0] KIND_SEARCH  = 3'd3;
  localparam logic [2:0] KIND_SORT    = 3'd4;
  localparam logic [2:0] KIND_DISPLAY = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Most results one display emits, and the width of the reported index
  localparam int MAX_RESULTS = 8;
  localparam int OUT_IDX_W   = 3;

endpackage

/* hdl/idtbl_store.sv */
// Entry storage of the ID table: one write port, one read port, registered read data.
// Depends on idtbl_pkg for the entry type.
module idtbl_store import idtbl_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int IW    = 3
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  id_t           wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output id_t           rd_data
);

  id_t mem [DEPTH];
  id_t rd_data_r;

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/id_table_insert_search_sort.sv */
// Table of up to DEPTH signed 32-bit IDs with a fill count; each item is one operation.
// Insert writes the entry when accepted, unless the table is full. Delete, update and search
// sweep the filled entries through the single read port, one entry a cycle, stopping at the
// first match where that applies. Display reads and emits one entry at a time, holding while
// the output register is busy (up to 8 results, last marked). Sort runs bubble passes over
// the table with one comparator, each pass one entry shorter. One item is in work at a time;
// the input stalls until its final result is in the output register.
// Entries are not cleared at reset; only filled entries are ever read.
`include "id_table_insert_search_sort_defines.svh"

module id_table_insert_search_sort import idtbl_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_kind,
  input  id_t                  in_id_value,
  input  id_t                  in_new_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [OUT_IDX_W-1:0] out_found_index,
  output id_t                  out_entry_value,
  output logic                 out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SORT, S_TAIL, S_DREAD, S_DEMIT, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        lim_r, lim_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic                 dv_r, dv_nxt;
  logic [IW-1:0]        dvi_r, dvi_nxt;
  logic [2:0]           kind_r, kind_nxt;
  id_t                  id_r, id_nxt;
  id_t                  new_r, new_nxt;
  logic                 any_r, any_nxt;
  id_t                  carry_r, carry_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic [OUT_IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  id_t                  out_value_r, out_value_nxt;
  logic                 out_last_r, out_last_nxt;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  id_t           wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  id_t           rd_data;

  logic          accept;
  logic          out_free;
  logic          full;
  logic          issue;
  logic          dv_last;
  logic          match;
  logic          gt;
  logic [CW-1:0] disp_n;

  idtbl_store #(.DEPTH(DEPTH), .IW(IW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake and status decode
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign issue    = (scan_r < lim_r);
  assign dv_last  = ((CW'(dvi_r) + CW'(1)) == lim_r);
  assign match    = (rd_data == id_r);
  assign gt       = (carry_r > rd_data);
  assign disp_n   = (32'(count_r) > MAX_RESULTS) ? CW'(MAX_RESULTS) : count_r;

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lim_nxt        = lim_r;
    scan_nxt       = scan_r;
    dv_nxt         = dv_r;
    dvi_nxt        = dvi_r;
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    new_nxt        = new_r;
    any_nxt        = any_r;
    carry_nxt      = carry_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = scan_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt    = in_kind;
          id_nxt      = in_id_value;
          new_nxt     = in_new_value;
          any_nxt     = 1'b0;
          scan_nxt    = '0;
          dv_nxt      = 1'b0;
          res_idx_nxt = '0;
          case (in_kind) inside
            KIND_INSERT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = count_r[IW-1:0];
                wr_data        = in_id_value;
                count_nxt      = count_r + CW'(1);
                res_status_nxt = ST_OK;
                res_idx_nxt    = OUT_IDX_W'(count_r);
              end
              state_nxt = S_DONE;
            end
            KIND_DELETE, KIND_UPDATE, KIND_SEARCH: begin
              lim_nxt = count_r;
              if (count_r == '0) begin
                res_status_nxt = ST_NOTFOUND;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            KIND_SORT: begin
              lim_nxt = count_r;
              if (count_r <= CW'(1)) begin
                res_status_nxt = ST_OK;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SORT;
              end
            end
            KIND_DISPLAY: begin
              lim_nxt = disp_n;
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_DREAD;
              end
            end
            default: begin
              // drop unused operation codes
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Sweep filled entries for delete, update and search
      S_SCAN: begin
        rd_en   = issue;
        dv_nxt  = issue;
        dvi_nxt = scan_r[IW-1:0];
        if (issue) begin
          scan_nxt = scan_r + CW'(1);
        end
        if (dv_r) begin
          case (kind_r)
            KIND_DELETE: begin
              if (match) begin
                wr_en   = 1'b1;
                wr_addr = dvi_r;
                wr_data = '0;
                any_nxt = 1'b1;
              end
              if (dv_last) begin
                res_status_nxt = (any_r || match) ? ST_OK : ST_NOTFOUND;
                state_nxt      = S_DONE;
              end
            end
            KIND_UPDATE: begin
              if (match) begin
                wr_en          = 1'b1;
                wr_addr        = dvi_r;
                wr_data        = new_r;
                res_status_nxt = ST_OK;
                res_idx_nxt    = OUT_IDX_W'(dvi_r);
                state_nxt      = S_DONE;
              end else if (dv_last) begin
                res_status_nxt = ST_NOTFOUND;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              if (match) begin
                res_status_nxt = ST_OK;
                res_idx_nxt    = OUT_IDX_W'(dvi_r);
                state_nxt      = S_DONE;
              end else if (dv_last) begin
                res_status_nxt = ST_NOTFOUND;
                state_nxt      = S_DONE;
              end
            end
          endcase
        end
      end

      // One bubble pass: carry the larger value, write back the smaller one
      S_SORT: begin
        rd_en   = issue;
        dv_nxt  = issue;
        dvi_nxt = scan_r[IW-1:0];
        if (issue) begin
          scan_nxt = scan_r + CW'(1);
        end
        if (dv_r) begin
          if (dvi_r == '0) begin
            carry_nxt = rd_data;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = dvi_r - IW'(1);
            wr_data   = gt ? rd_data : carry_r;
            carry_nxt = gt ? carry_r : rd_data;
          end
          if (dv_last) begin
            dv_nxt    = 1'b0;
            state_nxt = S_TAIL;
          end
        end
      end

      // Write the pass maximum to the end and shorten the next pass
      S_TAIL: begin
        wr_en    = 1'b1;
        wr_addr  = IW'(lim_r - CW'(1));
        wr_data  = carry_r;
        lim_nxt  = lim_r - CW'(1);
        scan_nxt = '0;
        if (lim_r == CW'(2)) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SORT;
        end
      end

      S_DREAD: begin
        rd_en     = 1'b1;
        state_nxt = S_DEMIT;
      end

      // Emit one display item; hold while the output register is busy
      S_DEMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_idx_nxt    = OUT_IDX_W'(scan_r);
          out_value_nxt  = rd_data;
          out_last_nxt   = ((scan_r + CW'(1)) == lim_r);
          if ((scan_r + CW'(1)) == lim_r) begin
            state_nxt = S_IDLE;
          end else begin
            scan_nxt  = scan_r + CW'(1);
            state_nxt = S_DREAD;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lim_r        <= lim_nxt;
    scan_r       <= scan_nxt;
    dvi_r        <= dvi_nxt;
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    new_r        <= new_nxt;
    any_r        <= any_nxt;
    carry_r      <= carry_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_idx_r;
  assign out_entry_value = out_value_r;
  assign out_last        = out_last_r;

  // Checks on the table control
  `IDT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "fill count above depth")
  `IDT_ASSERT_NOW(a_port_conflict, wr_en && rd_en, wr_addr != rd_addr,
                  "read and write hit same entry")
  `IDT_ASSERT_NEXT(a_insert_count, accept && in_kind == KIND_INSERT && !full,
                   count_r == $past(count_r) + CW'(1), "insert did not advance count")

endmodule
